// ===== sv/twlcd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// twlcd_pkg
// shared constants and types of the two-way lru cache tag directory
// ---------------------------------------------------------------------------
package twlcd_pkg;

    localparam int ADDR_W    = 7;
    localparam int NUM_SETS  = 4;
    localparam int MEM_WORDS = 128;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int TAG_W     = MEM_AW - SET_W;
    localparam int CNT_W     = 32;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOKUP
    } state_t;

    // one memory row holds the tags of both ways of a set
    typedef logic [1:0][TAG_W-1:0] tag_row_t;

    typedef struct packed {
        logic              hit;
        logic              way;
        logic              ev_valid;
        logic [ADDR_W-1:0] ev_addr;
        logic              new_lru;
        tag_row_t          new_row;
    } decision_t;

endpackage
`default_nettype wire

// ===== sv/twlcd_tag_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// twlcd_tag_ram
// tag memory, one row per set, one write and one registered read port
// ---------------------------------------------------------------------------
module twlcd_tag_ram (
    input  wire logic                                clk,
    input  wire logic                                rd_en,
    input  wire logic [twlcd_pkg::SET_W-1:0]         rd_addr,
    output twlcd_pkg::tag_row_t                      rd_data,
    input  wire logic                                wr_en,
    input  wire logic [twlcd_pkg::SET_W-1:0]         wr_addr,
    input  wire twlcd_pkg::tag_row_t                 wr_data
);

    twlcd_pkg::tag_row_t mem [twlcd_pkg::NUM_SETS];
    twlcd_pkg::tag_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/twlcd_decide.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// twlcd_decide
// compares both ways of a set and picks the hit, fill or victim way
// ---------------------------------------------------------------------------
module twlcd_decide (
    input  wire logic [twlcd_pkg::TAG_W-1:0] tag,
    input  wire logic [twlcd_pkg::SET_W-1:0] set_idx,
    input  wire logic [1:0]                  valid,
    input  wire logic                        lru,
    input  wire twlcd_pkg::tag_row_t         row,
    output twlcd_pkg::decision_t             dec
);

    localparam int AW = twlcd_pkg::ADDR_W;

    always_comb
    begin
        logic m0;
        logic m1;
        logic sel;
        m0  = valid[0] && (row[0] == tag);
        m1  = valid[1] && (row[1] == tag);
        sel = 1'b0;
        dec = '0;
        dec.new_row = row;
        if (m0 || m1)
        begin
            sel         = !m0;
            dec.hit     = 1'b1;
            dec.way     = sel;
            // way 1 stays lru while it is empty
            dec.new_lru = valid[1] ? !sel : 1'b1;
        end
        else
        begin
            if (!valid[0])
            begin
                sel = 1'b0;
            end
            else if (!valid[1])
            begin
                sel = 1'b1;
            end
            else
            begin
                sel          = lru;
                dec.ev_valid = 1'b1;
                dec.ev_addr  = AW'({row[sel], set_idx});
            end
            dec.way          = sel;
            dec.new_row[sel] = tag;
            dec.new_lru      = !sel;
        end
    end

endmodule
`default_nettype wire

// ===== sv/two_way_lru_cache_directory_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// two_way_lru_cache_directory_top
// tag directory of a two-way set-associative cache with one lru bit per set
// ---------------------------------------------------------------------------
// Each address transfer is looked up in its set; the result (hit, way,
// evicted address and the saturating hit and miss counts) appears in the
// output register once the lookup state commits it. The tag memory is
// read in the cycle of the transfer and the same row is compared, and on
// a miss written back, in the lookup state, so lookups never overlap. A
// new address is taken while a result still waits on the output; the
// following lookup then holds until that result is taken. Valid and lru
// bits are flip-flops cleared by reset, so no clearing pass is needed.
module two_way_lru_cache_directory_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [twlcd_pkg::ADDR_W-1:0]  address,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic                               way,
    output logic                               evicted_valid,
    output logic [twlcd_pkg::ADDR_W-1:0]       evicted_address,
    output logic [twlcd_pkg::CNT_W-1:0]        hits_so_far,
    output logic [twlcd_pkg::CNT_W-1:0]        misses_so_far
);

    localparam int NS    = twlcd_pkg::NUM_SETS;
    localparam int SET_W = twlcd_pkg::SET_W;
    localparam int TAG_W = twlcd_pkg::TAG_W;
    localparam int MEM_AW = twlcd_pkg::MEM_AW;
    localparam int CNT_W = twlcd_pkg::CNT_W;
    localparam int AW    = twlcd_pkg::ADDR_W;

    twlcd_pkg::state_t state_reg, state_next;

    logic [SET_W-1:0]       set_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [NS-1:0][1:0]     valid_reg;
    logic [NS-1:0]          lru_reg;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic [CNT_W-1:0]       misses_reg, misses_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg;
    logic                   way_reg;
    logic                   ev_valid_reg;
    logic [AW-1:0]          ev_addr_reg;

    logic                   accept;
    logic                   commit;
    logic [MEM_AW-1:0]      addr_eff;
    twlcd_pkg::tag_row_t    rd_row;
    twlcd_pkg::decision_t   dec;

    // address wraps into memory size
    assign addr_eff = address[MEM_AW-1:0];

    twlcd_tag_ram u_tag_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (addr_eff[SET_W-1:0]),
        .rd_data (rd_row),
        .wr_en   (commit && !dec.hit),
        .wr_addr (set_reg),
        .wr_data (dec.new_row)
    );

    twlcd_decide u_decide (
        .tag     (tag_reg),
        .set_idx (set_reg),
        .valid   (valid_reg[set_reg]),
        .lru     (lru_reg[set_reg]),
        .row     (rd_row),
        .dec     (dec)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        commit         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            twlcd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = twlcd_pkg::S_LOOKUP;
                end
            end
            twlcd_pkg::S_LOOKUP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = twlcd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = twlcd_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (commit && dec.hit && (hits_reg != '1))
        begin
            hits_next = hits_reg + CNT_W'(1);
        end
        if (commit && !dec.hit && (misses_reg != '1))
        begin
            misses_next = misses_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twlcd_pkg::S_IDLE;
            valid_reg     <= '0;
            lru_reg       <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                lru_reg[set_reg] <= dec.new_lru;
                if (!dec.hit)
                begin
                    valid_reg[set_reg][dec.way] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= addr_eff[SET_W-1:0];
            tag_reg <= addr_eff[MEM_AW-1:SET_W];
        end
        if (commit)
        begin
            hit_reg      <= dec.hit;
            way_reg      <= dec.way;
            ev_valid_reg <= dec.ev_valid;
            ev_addr_reg  <= dec.ev_addr;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign way             = way_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_address = ev_addr_reg;
    assign hits_so_far     = hits_reg;
    assign misses_so_far   = misses_reg;

    a_hits_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg >= $past(hits_reg))
        else $error("hit count decreased");

    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        commit && dec.hit |=> $stable(misses_reg))
        else $error("miss count moved on a hit");

    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !dec.hit |=> valid_reg[$past(set_reg)][$past(dec.way)])
        else $error("filled way not marked valid");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(commit))
        else $error("result shown without a lookup");

endmodule
`default_nettype wire
